// File: hw/rtl/cpt_pkg.sv
`timescale 1ns / 1ps

package cpt_pkg;

    localparam int CAP_W    = 16;
    localparam int PERIOD_W = 17;
    localparam int SPEED_W  = 24;
    localparam int DIVISOR_W = 19;
    localparam int DIVIDEND_W = 26;

    // 1 MHz timer * 60 s/min
    localparam logic [DIVIDEND_W-1:0] DIVIDEND = 26'd60000000;
    localparam logic [PERIOD_W-1:0]   FULL_WRAP = 17'h10000;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                channel;
        logic [PERIOD_W-1:0] period;
        logic                updated;
    } work_t;

endpackage

// File: hw/rtl/cpt_queue.sv
`timescale 1ns / 1ps

module cpt_queue #(
    parameter int DEPTH = cpt_pkg::QUEUE_DEPTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cpt_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output cpt_pkg::work_t pop_data,
    output logic           empty
);
    import cpt_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    work_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign full     = (cnt_reg == FULL_CNT);
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: hw/rtl/cpt_front.sv
`timescale 1ns / 1ps

module cpt_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic                            channel_sel,
    input  logic [cpt_pkg::CAP_W-1:0]       capture_value,
    output cpt_pkg::work_t                  work
);
    import cpt_pkg::*;

    logic [CAP_W-1:0] prev_reg [2];
    logic [CAP_W-1:0] prev;
    logic [CAP_W-1:0] diff;

    assign prev = prev_reg[channel_sel];
    assign diff = capture_value - prev;

    always_comb
    begin
        work.channel = channel_sel;
        work.updated = (prev != '0);
        if (prev == '0)
        begin
            work.period = '0;
        end
        else if (diff == '0)
        begin
            work.period = FULL_WRAP;
        end
        else
        begin
            work.period = {1'b0, diff};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg[0] <= '0;
            prev_reg[1] <= '0;
        end
        else if (accept)
        begin
            prev_reg[channel_sel] <= capture_value;
        end
    end

endmodule

// File: hw/rtl/cpt_back.sv
`timescale 1ns / 1ps

module cpt_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  cpt_pkg::work_t               q_data,
    output logic                         q_pop,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         out_channel,
    output logic [cpt_pkg::PERIOD_W-1:0] period_ticks,
    output logic [cpt_pkg::SPEED_W-1:0]  speed_rpm,
    output logic                         speed_updated
);
    import cpt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;
    localparam int STEP_W = $clog2(DIVIDEND_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIVIDEND_W - 1);

    logic [1:0]            state_reg, state_next;
    logic [STEP_W-1:0]     step_reg, step_next;
    work_t                 item_reg, item_next;
    logic [DIVISOR_W-1:0]  div_reg, div_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [SPEED_W-1:0]    held_reg [2];

    logic                  res_valid_reg, res_valid_next;
    logic                  res_ch_reg;
    logic [PERIOD_W-1:0]   res_period_reg;
    logic [SPEED_W-1:0]    res_speed_reg;
    logic                  res_upd_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic [DIVISOR_W:0]    times7;
    logic [STEP_W-1:0]     bit_idx;
    logic                  load_out;
    logic [SPEED_W-1:0]    new_speed;

    assign bit_idx   = LAST_STEP - step_reg;
    assign rem_shift = {rem_reg, DIVIDEND[bit_idx]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign times7    = {q_data.period, 3'b000} - {3'b000, q_data.period};
    assign load_out  = (state_reg == ST_DONE) && (!res_valid_reg || !res_stall);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;
    assign new_speed = item_reg.updated ? quo_reg[SPEED_W-1:0] : held_reg[item_reg.channel];

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        item_next      = item_reg;
        div_next       = div_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        res_valid_next = res_valid_reg;
        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    item_next = q_data;
                    div_next  = times7[DIVISOR_W-1:0];
                    rem_next  = '0;
                    quo_next  = '0;
                    step_next = '0;
                    state_next = q_data.updated ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (rem_shift >= {1'b0, div_reg})
                begin
                    rem_next = rem_diff[DIVISOR_W-1:0];
                    quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_shift[DIVISOR_W-1:0];
                    quo_next = {quo_reg[DIVIDEND_W-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    res_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
            held_reg[0]   <= '0;
            held_reg[1]   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            if (load_out)
            begin
                held_reg[item_reg.channel] <= new_speed;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg <= step_next;
        item_reg <= item_next;
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        if (load_out)
        begin
            res_ch_reg     <= item_reg.channel;
            res_period_reg <= item_reg.period;
            res_speed_reg  <= new_speed;
            res_upd_reg    <= item_reg.updated;
        end
    end

    assign res_valid     = res_valid_reg;
    assign out_channel   = res_ch_reg;
    assign period_ticks  = res_period_reg;
    assign speed_rpm     = res_speed_reg;
    assign speed_updated = res_upd_reg;

endmodule

// File: hw/rtl/capture_period_tachometer_unit.sv
`timescale 1ns / 1ps
// Two-channel capture period tachometer.
// Capture channel: cap_valid/cap_stall carry channel_sel and capture_value,
// one rising-edge timer capture per transaction.
// Result channel: res_valid/res_stall carry out_channel, period_ticks,
// speed_rpm and speed_updated, exactly one result per capture, in order.
// The front stores the previous capture per channel and forms the period;
// a small queue (FIFO_DEPTH entries) feeds the back end, which divides
// 60000000 by 7 * period one quotient bit per cycle.
// The speed is recomputed unless the previous capture on that channel is
// zero; then the stored speed is held. The back end works on one capture
// at a time and pops the next only when it is idle.
// cap_stall rises when the queue is full. A result waits in the output
// register while res_stall is high; the front keeps accepting until the
// queue fills.
// Reset clears stored captures and speeds to zero and drops any pending work.
module capture_period_tachometer_unit #(
    parameter int FIFO_DEPTH = cpt_pkg::QUEUE_DEPTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cap_valid,
    output logic                         cap_stall,
    input  logic                         channel_sel,
    input  logic [cpt_pkg::CAP_W-1:0]    capture_value,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         out_channel,
    output logic [cpt_pkg::PERIOD_W-1:0] period_ticks,
    output logic [cpt_pkg::SPEED_W-1:0]  speed_rpm,
    output logic                         speed_updated
);
    import cpt_pkg::*;

    work_t front_work;
    work_t q_data;
    logic  q_full, q_empty, q_pop, accept;

    assign cap_stall = q_full;
    assign accept    = cap_valid && !q_full;

    cpt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .channel_sel   (channel_sel),
        .capture_value (capture_value),
        .work          (front_work)
    );

    cpt_queue #(
        .DEPTH (FIFO_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_work),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    cpt_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_data),
        .q_pop         (q_pop),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_channel   (out_channel),
        .period_ticks  (period_ticks),
        .speed_rpm     (speed_rpm),
        .speed_updated (speed_updated)
    );

`ifndef SYNTH
    a_held_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !speed_updated |-> period_ticks == '0)
        else $error("held speed with nonzero period");

    a_full_wrap_speed: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && speed_updated && period_ticks == FULL_WRAP |-> speed_rpm == 24'd130)
        else $error("wrong speed for full timer wrap");

    a_updated_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && speed_updated |-> speed_rpm != '0 && period_ticks != '0)
        else $error("recomputed speed or period is zero");
`endif

endmodule

// File: tb/tb_capture_period_tachometer_unit.sv
`timescale 1ns / 1ps

module tb_capture_period_tachometer_unit;

    localparam int unsigned TICKS_PER_MIN = 60_000_000;
    localparam int unsigned EDGES_PER_REV = 7;
    localparam int unsigned FULL_WRAP     = 65536;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned QUIET_TAIL    = 120;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 40;
    localparam int unsigned CYCLE_LIMIT   = 200_000;

    typedef struct {
        logic                         channel;
        logic [cpt_pkg::PERIOD_W-1:0] period;
        logic [cpt_pkg::SPEED_W-1:0]  speed;
        logic                         updated;
    } wheel_reading_t;

    class tach_tracker;
        logic [cpt_pkg::CAP_W-1:0]   last_edge [2];
        logic [cpt_pkg::SPEED_W-1:0] wheel_rpm [2];
        wheel_reading_t              pending_readings [$];
        int                          errors;

        function new();
            last_edge[0] = '0;
            last_edge[1] = '0;
            wheel_rpm[0] = '0;
            wheel_rpm[1] = '0;
            errors = 0;
        endfunction

        function void note_capture(logic ch, logic [cpt_pkg::CAP_W-1:0] cap);
            wheel_reading_t            r;
            logic [cpt_pkg::CAP_W-1:0] delta;
            int unsigned               p;
            r.channel = ch;
            r.period  = '0;
            r.updated = 1'b0;
            if (last_edge[ch] != '0)
            begin
                delta = cap - last_edge[ch];
                p = (delta == '0) ? FULL_WRAP : int'(delta);
                r.period = p[cpt_pkg::PERIOD_W-1:0];
                wheel_rpm[ch] = 24'(TICKS_PER_MIN / (EDGES_PER_REV * p));
                r.updated = 1'b1;
            end
            last_edge[ch] = cap;
            r.speed = wheel_rpm[ch];
            pending_readings.push_back(r);
        endfunction

        function void check_reading(logic ch, logic [cpt_pkg::PERIOD_W-1:0] period,
                                    logic [cpt_pkg::SPEED_W-1:0] speed, logic updated);
            wheel_reading_t r;
            if (pending_readings.size() == 0)
            begin
                $display("%0t: unexpected result ch=%0d period=%0d rpm=%0d upd=%0d",
                         $time, ch, period, speed, updated);
                errors++;
                return;
            end
            r = pending_readings.pop_front();
            if (ch !== r.channel)
            begin
                $display("%0t: out_channel expected %0d actual %0d", $time, r.channel, ch);
                errors++;
            end
            if (period !== r.period)
            begin
                $display("%0t: period_ticks expected %0d actual %0d", $time, r.period, period);
                errors++;
            end
            if (speed !== r.speed)
            begin
                $display("%0t: speed_rpm expected %0d actual %0d", $time, r.speed, speed);
                errors++;
            end
            if (updated !== r.updated)
            begin
                $display("%0t: speed_updated expected %0d actual %0d",
                         $time, r.updated, updated);
                errors++;
            end
        endfunction

        function int pending();
            return pending_readings.size();
        endfunction
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         cap_valid = 1'b0;
    logic                         cap_stall;
    logic                         channel_sel = 1'b0;
    logic [cpt_pkg::CAP_W-1:0]    capture_value = '0;
    logic                         res_valid;
    logic                         res_stall = 1'b0;
    logic                         out_channel;
    logic [cpt_pkg::PERIOD_W-1:0] period_ticks;
    logic [cpt_pkg::SPEED_W-1:0]  speed_rpm;
    logic                         speed_updated;

    bit                           idle_on = 1'b1;
    bit                           hold_request = 1'b0;
    int unsigned                  cycle_count = 0;
    logic [cpt_pkg::CAP_W-1:0]    last_sent [2] = '{16'h0, 16'h0};
    tach_tracker                  tracker = new();

    capture_period_tachometer_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cap_valid     (cap_valid),
        .cap_stall     (cap_stall),
        .channel_sel   (channel_sel),
        .capture_value (capture_value),
        .res_valid     (res_valid),
        .res_stall     (res_stall),
        .out_channel   (out_channel),
        .period_ticks  (period_ticks),
        .speed_rpm     (speed_rpm),
        .speed_updated (speed_updated)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result first, then the capture taken at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (res_valid && !res_stall)
                tracker.check_reading(out_channel, period_ticks, speed_rpm, speed_updated);
            if (cap_valid && !cap_stall)
                tracker.note_capture(channel_sel, capture_value);
        end
    end

    // result-side backpressure
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                res_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                res_stall <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 4) == 0)
            begin
                res_stall <= 1'b1;
                repeat ($urandom_range(1, 7)) @(negedge clk);
                res_stall <= 1'b0;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // called and returns at a falling edge
    task automatic send_capture(input logic ch, input logic [cpt_pkg::CAP_W-1:0] cap);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 7) : 0;
        if (gap != 0)
        begin
            cap_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cap_valid     <= 1'b1;
        channel_sel   <= ch;
        capture_value <= cap;
        do
            @(posedge clk);
        while (cap_stall);
        @(negedge clk);
        last_sent[ch] = cap;
    endtask

    task automatic send_random_capture();
        logic                      ch;
        logic [cpt_pkg::CAP_W-1:0] cap;
        int unsigned               mode;
        ch   = 1'($urandom_range(0, 1));
        mode = $urandom_range(0, 9);
        if (mode <= 3)
            cap = last_sent[ch] + 16'($urandom_range(1, 40));
        else if (mode <= 5)
            cap = last_sent[ch] + 16'($urandom_range(1, 65535));
        else if (mode == 6)
            cap = last_sent[ch];
        else if (mode == 7)
            cap = 16'($urandom);
        else if (mode == 8)
            cap = '0;
        else
            cap = last_sent[ch] - 16'($urandom_range(1, 40));
        send_capture(ch, cap);
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_capture(1'b0, 16'h1234);   // no previous edge: held
        send_capture(1'b0, 16'h1234);   // equal: full wrap
        send_capture(1'b0, 16'h1235);   // period 1: top speed
        send_capture(1'b1, 16'hffff);
        send_capture(1'b0, 16'h0005);   // wraps
        send_capture(1'b1, 16'h0000);   // zero capture, period 1
        send_capture(1'b1, 16'h0001);   // previous zero: held
        send_capture(1'b0, 16'hffff);
        send_capture(1'b1, 16'h0001);
        send_capture(1'b0, 16'h0000);
        send_capture(1'b0, 16'h8000);
        send_capture(1'b0, 16'h8007);
        send_capture(1'b1, 16'haaaa);
        send_capture(1'b1, 16'h5555);
        send_capture(1'b0, 16'h7fff);
        send_capture(1'b1, 16'h5556);
        send_capture(1'b0, 16'h7ffe);
        send_capture(1'b1, 16'h5555);

        for (int unsigned n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 200)
                hold_request = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_TAIL)
                idle_on = 1'b0;
            send_random_capture();
        end
        cap_valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
